@@ design/ttw_pkg.sv @@
`timescale 1ns / 1ps

package ttw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COPY_COUNT     = SCREEN_COLUMNS * (SCREEN_ROWS - 1);
  localparam int IDX_W          = 11;

  localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
  localparam logic [1:0] CMD_PUT_AT   = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  localparam logic [7:0]  CH_NEWLINE    = 8'd10;
  localparam logic [7:0]  CH_BACKSPACE  = 8'd8;
  localparam logic [7:0]  CH_SPACE      = 8'h20;
  localparam logic [7:0]  GREY_ON_BLACK = 8'h07;
  localparam logic [15:0] CELL_BLANK    = {GREY_ON_BLACK, CH_SPACE};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
  } in_t;

  typedef struct packed {
    logic             cell_written;
    logic [IDX_W-1:0] write_index;
    logic [15:0]      write_value;
    logic [15:0]      read_value;
    logic [IDX_W-1:0] cursor_position;
    logic             did_scroll;
    logic             bad_position;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic copy_step;
    logic fill_step;
    logic fill_grey;
    logic capture_read;
    logic emit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic need_scroll;
    logic read_ok;
    logic copy_last;
    logic fill_last;
  } stat_t;

endpackage

@@ design/text_terminal_writer.sv @@
`timescale 1ns / 1ps
// accept to done strobe: put, put-at and bad positions pass exec and done, a read
// adds a read state, a put that scrolls copies 1920 cells up a row, drains, then
// fills the 80 last-row cells, and clear fills all 2000 cells; a new word can be
// taken at the edge that ends the done cycle. The screen store has one write and
// one read port, walked one cell per cycle. Reset (synchronous, active high) fills
// all 2000 cells with grey spaces under busy; the receiver never stalls results.

module text_terminal_writer (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ttw_pkg::in_t  item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data,
  output logic          done,
  output ttw_pkg::out_t result
);
  import ttw_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ttw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  ttw_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .stat     (stat),
    .done     (done),
    .result   (result)
  );

endmodule

@@ design/ttw_ctrl.sv @@
`timescale 1ns / 1ps

module ttw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ttw_pkg::stat_t stat,
  output ttw_pkg::ctrl_t ctrl,
  output logic          busy
);
  import ttw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_READ, S_COPY, S_DRAIN, S_FILL, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  if (stat.fill_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC: begin
        priority if (stat.is_clear)    state_next = S_FILL;
        else if (stat.need_scroll)     state_next = S_COPY;
        else if (stat.read_ok)         state_next = S_READ;
        else                           state_next = S_DONE;
      end
      S_READ:  state_next = S_DONE;
      S_COPY:  if (stat.copy_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_FILL;
      S_FILL:  if (stat.fill_last) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    ctrl              = '0;
    ctrl.latch        = (state == S_IDLE) && start;
    ctrl.exec         = (state == S_EXEC);
    ctrl.copy_step    = (state == S_COPY);
    ctrl.fill_step    = (state == S_FILL) || (state == S_INIT);
    ctrl.fill_grey    = (state == S_INIT);
    ctrl.capture_read = (state == S_READ);
    ctrl.emit         = (state == S_DONE);
  end

endmodule

@@ design/ttw_datapath.sv @@
`timescale 1ns / 1ps

module ttw_datapath (
  input  logic          clk,
  input  logic          rst,
  input  ttw_pkg::in_t  item,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  ttw_pkg::ctrl_t ctrl,
  output ttw_pkg::stat_t stat,
  output logic          done,
  output ttw_pkg::out_t result
);
  import ttw_pkg::*;

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rd_data;

  in_t              item_q;
  logic [7:0]       text_attribute;
  logic [4:0]       cursor_row;
  logic [6:0]       cursor_col;
  logic [IDX_W-1:0] sweep;
  logic             copy_pending;
  logic [IDX_W-1:0] copy_waddr;

  logic             written;
  logic [IDX_W-1:0] widx;
  logic [15:0]      wval;
  logic [15:0]      rval;
  logic             scrolled;
  logic             bad;

  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             pos_bad;
  logic             at_last_col;
  logic             at_last_row;
  logic             is_nl;
  logic             is_bs;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [15:0]      wdata;

  assign cur_idx = IDX_W'(cursor_row) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(cursor_col);
  assign pos_idx = IDX_W'(item_q.pos_y) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(item_q.pos_x);
  assign pos_bad = (item_q.pos_x >= 7'(SCREEN_COLUMNS)) || (item_q.pos_y >= 5'(SCREEN_ROWS));
  assign at_last_col = (cursor_col == 7'(SCREEN_COLUMNS - 1));
  assign at_last_row = (cursor_row == 5'(SCREEN_ROWS - 1));
  assign is_nl = (item_q.char_code == CH_NEWLINE);
  assign is_bs = (item_q.char_code == CH_BACKSPACE);

  assign stat.is_clear    = (item_q.cmd == CMD_CLEAR);
  assign stat.need_scroll = (item_q.cmd == CMD_PUT_CHAR) && at_last_row
                            && (is_nl || (!is_bs && at_last_col));
  assign stat.read_ok     = (item_q.cmd == CMD_READ) && !pos_bad;
  assign stat.copy_last   = (sweep == IDX_W'(COPY_COUNT - 1));
  assign stat.fill_last   = (sweep == IDX_W'(CELL_COUNT - 1));

  // single write port shared by the item's own write, the scroll copy and fills
  always_comb begin
    we    = 1'b0;
    waddr = sweep;
    wdata = CELL_BLANK;
    priority if (ctrl.exec) begin
      unique case (item_q.cmd)
        CMD_PUT_CHAR: begin
          if (is_bs) begin
            we    = (cursor_col != 7'd0);
            waddr = cur_idx - IDX_W'(1);
            wdata = CELL_BLANK;
          end else if (!is_nl) begin
            we    = 1'b1;
            waddr = cur_idx;
            wdata = {text_attribute, item_q.char_code};
          end
        end
        CMD_PUT_AT: begin
          we    = !pos_bad;
          waddr = pos_idx;
          wdata = {item_q.bg_color, item_q.fg_color, item_q.char_code};
        end
        CMD_READ, CMD_CLEAR: begin
          we = 1'b0;
        end
      endcase
    end else if (copy_pending) begin
      we    = 1'b1;
      waddr = copy_waddr;
      wdata = rd_data;
    end else if (ctrl.fill_step) begin
      we    = 1'b1;
      waddr = sweep;
      wdata = ctrl.fill_grey ? CELL_BLANK : {text_attribute, CH_SPACE};
    end else begin
      we = 1'b0;
    end
  end

  // scroll reads one row ahead of where it writes
  assign rd_addr = ctrl.exec ? pos_idx : sweep + IDX_W'(SCREEN_COLUMNS);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      item_q <= item;
    end
    if (ctrl.exec) begin
      written  <= we;
      widx     <= we ? waddr : '0;
      wval     <= we ? wdata : '0;
      rval     <= '0;
      scrolled <= stat.need_scroll;
      bad      <= pos_bad && ((item_q.cmd == CMD_PUT_AT) || (item_q.cmd == CMD_READ));
    end
    if (ctrl.capture_read) begin
      rval <= rd_data;
    end
    copy_waddr <= sweep;
    if (ctrl.emit) begin
      result.cell_written    <= written;
      result.write_index     <= widx;
      result.write_value     <= wval;
      result.read_value      <= rval;
      result.cursor_position <= cur_idx;
      result.did_scroll      <= scrolled;
      result.bad_position    <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= GREY_ON_BLACK;
      cursor_row     <= '0;
      cursor_col     <= '0;
      sweep          <= '0;
      copy_pending   <= 1'b0;
      done           <= 1'b0;
    end else begin
      done         <= ctrl.emit;
      copy_pending <= ctrl.copy_step;
      if (cfg_we) begin
        text_attribute <= cfg_data;
      end
      if (ctrl.exec) begin
        sweep <= '0;
      end else if (ctrl.copy_step || ctrl.fill_step) begin
        sweep <= sweep + IDX_W'(1);
      end
      if (ctrl.exec) begin
        unique case (item_q.cmd)
          CMD_PUT_CHAR: begin
            if (is_nl) begin
              cursor_col <= '0;
              if (!at_last_row) cursor_row <= cursor_row + 5'd1;
            end else if (is_bs) begin
              if (cursor_col != 7'd0) cursor_col <= cursor_col - 7'd1;
            end else if (at_last_col) begin
              cursor_col <= '0;
              if (!at_last_row) cursor_row <= cursor_row + 5'd1;
            end else begin
              cursor_col <= cursor_col + 7'd1;
            end
          end
          CMD_CLEAR: begin
            cursor_row <= '0;
            cursor_col <= '0;
          end
          CMD_PUT_AT, CMD_READ: begin
            cursor_row <= cursor_row;
          end
        endcase
      end
    end
  end

endmodule

@@ design/ttw_checker.sv @@
`timescale 1ns / 1ps

module ttw_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ttw_pkg::out_t result
);
  import ttw_pkg::*;

  // a word taken makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // result never comes out the cycle right after accept
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too early");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.cursor_position < IDX_W'(CELL_COUNT)))
    else $error("cursor off screen");

  a_bad_no_effect: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_position) |->
      (!result.cell_written && (result.read_value == 16'd0) && !result.did_scroll))
    else $error("bad position had an effect");

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
